// ===== rtl/kmp_nextval_matcher_top_defines.svh =====
// ----------------------------------------------------------------------------
// kmp_nextval_matcher_top_defines: assertion macros
// Shared property wrappers for the matcher; clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef KMP_NEXTVAL_MATCHER_TOP_DEFINES_SVH
`define KMP_NEXTVAL_MATCHER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants
// Port widths, operation and register codes, and the per-cell write enables.
// ----------------------------------------------------------------------------
package kmp_pkg;

	// Fixed port widths
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned CIDX_W = 2;
	localparam int unsigned LEN_W  = 6;
	localparam int unsigned POS_W  = 32;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned SYM_W  = 8;
	localparam int unsigned SLOT_W = 6;

	// Operation codes of an input beat
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_TEXT  = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_SEARCH_START   = 2'd1,
		REG_INIT_POSITION  = 2'd2
	} reg_idx_t;

	// Write enables into one pattern cell
	typedef struct packed {
		logic sym_we;
		logic brd_we;
		logic nv_we;
	} cell_we_t;

endpackage

// ===== rtl/kmp_cell.sv =====
// ----------------------------------------------------------------------------
// kmp_cell: one pattern position
// Holds the pattern symbol, its border length and its nextval entry, compares
// the symbol against the broadcast key and forms the next entry from the
// border handed over by the left neighbor.
// ----------------------------------------------------------------------------
module kmp_cell #(
	parameter int unsigned SYMBOL_BITS = 8,
	parameter int unsigned IW          = 6
) (
	input  logic                   clk,
	input  kmp_pkg::cell_we_t      we,
	input  logic [SYMBOL_BITS-1:0] sym_wdata,
	input  logic [IW-1:0]          brd_wdata,
	input  logic [IW-1:0]          nv_wdata,
	input  logic [SYMBOL_BITS-1:0] key,
	input  logic [IW-1:0]          left_brd,
	output logic [SYMBOL_BITS-1:0] sym,
	output logic [IW-1:0]          brd,
	output logic [IW-1:0]          nv,
	output logic [IW-1:0]          nxt,
	output logic                   eq
);
	import kmp_pkg::*;

	logic [SYMBOL_BITS-1:0] sym_q;
	logic [IW-1:0]          brd_q;
	logic [IW-1:0]          nv_q;

	// Cell storage, no reset: written by load and build
	always_ff @(posedge clk) begin
		if (we.sym_we) begin
			sym_q <= sym_wdata;
		end
		if (we.brd_we) begin
			brd_q <= brd_wdata;
		end
		if (we.nv_we) begin
			nv_q <= nv_wdata;
		end
	end

	// Key compare and next entry from the left neighbor's border
	assign eq  = (sym_q == key);
	assign nxt = left_brd + IW'(1);
	assign sym = sym_q;
	assign brd = brd_q;
	assign nv  = nv_q;

endmodule

// ===== rtl/kmp_cell_row.sv =====
// ----------------------------------------------------------------------------
// kmp_cell_row: row of pattern cells
// Chains the border of each cell into its right neighbor, decodes one write
// position and selects the cells that the controller looks at.
// ----------------------------------------------------------------------------
module kmp_cell_row #(
	parameter int unsigned MAX_PATTERN = 32,
	parameter int unsigned SYMBOL_BITS = 8
) (
	input  logic                                  clk,
	input  logic [$clog2(MAX_PATTERN)-1:0]        wr_idx,
	input  kmp_pkg::cell_we_t                     wr_we,
	input  logic [SYMBOL_BITS-1:0]                sym_wdata,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]      brd_wdata,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]      nv_wdata,
	input  logic [SYMBOL_BITS-1:0]                key,
	input  logic [$clog2(MAX_PATTERN)-1:0]        rd_a_idx,
	input  logic [$clog2(MAX_PATTERN)-1:0]        rd_b_idx,
	input  logic [$clog2(MAX_PATTERN)-1:0]        rd_c_idx,
	output logic [SYMBOL_BITS-1:0]                sym_a,
	output logic [$clog2(MAX_PATTERN+1)-1:0]      nxt_a,
	output logic                                  eq_b,
	output logic [$clog2(MAX_PATTERN+1)-1:0]      nv_b,
	output logic [$clog2(MAX_PATTERN+1)-1:0]      brd_c
);
	import kmp_pkg::*;

	localparam int unsigned IW = $clog2(MAX_PATTERN + 1);
	localparam int unsigned AW = $clog2(MAX_PATTERN);

	logic [SYMBOL_BITS-1:0] cell_sym  [MAX_PATTERN];
	logic [IW-1:0]          cell_brd  [MAX_PATTERN];
	logic [IW-1:0]          cell_nv   [MAX_PATTERN];
	logic [IW-1:0]          cell_nxt  [MAX_PATTERN];
	logic [IW-1:0]          cell_left [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_eq;

	// Cells; position 1 has no proper prefix, its next entry is never read
	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		cell_we_t we_g;

		if (g == 0) begin : g_first
			assign cell_left[g] = '0;
		end else begin : g_chain
			assign cell_left[g] = cell_brd[g-1];
		end

		assign we_g = (wr_idx == AW'(g)) ? wr_we : '0;

		kmp_cell #(
			.SYMBOL_BITS(SYMBOL_BITS),
			.IW         (IW)
		) u_cell (
			.clk      (clk),
			.we       (we_g),
			.sym_wdata(sym_wdata),
			.brd_wdata(brd_wdata),
			.nv_wdata (nv_wdata),
			.key      (key),
			.left_brd (cell_left[g]),
			.sym      (cell_sym[g]),
			.brd      (cell_brd[g]),
			.nv       (cell_nv[g]),
			.nxt      (cell_nxt[g]),
			.eq       (cell_eq[g])
		);
	end

	// Cell selection for the controller
	assign sym_a = cell_sym[rd_a_idx];
	assign nxt_a = cell_nxt[rd_a_idx];
	assign eq_b  = cell_eq[rd_b_idx];
	assign nv_b  = cell_nv[rd_b_idx];
	assign brd_c = cell_brd[rd_c_idx];

endmodule

// ===== rtl/kmp_nextval_matcher_top.sv =====
// ----------------------------------------------------------------------------
// kmp_nextval_matcher_top: KMP search over a row of pattern cells
// Load writes the symbol; text checks the cursor in ST_TXT, again per nextval
// jump; build runs ST_BLD_LOAD, ST_BLD_NV, ST_BLD_SCAN per position, redoing
// ST_BLD_SCAN per border fallback (none at length one). No beat is taken while
// busy, and results cannot be stalled. Reset is async.
// ----------------------------------------------------------------------------
`include "kmp_nextval_matcher_top_defines.svh"

module kmp_nextval_matcher_top #(
	parameter int unsigned MAX_PATTERN = 32,
	parameter int unsigned SYMBOL_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// config write port
	input  logic                         cfg_we,
	input  logic [kmp_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [kmp_pkg::CFG_W-1:0]    cfg_data,
	// command
	input  logic                         start,
	output logic                         busy,
	input  logic [kmp_pkg::OP_W-1:0]     operation,
	input  logic [kmp_pkg::SYM_W-1:0]    symbol,
	input  logic [kmp_pkg::SLOT_W-1:0]   pattern_slot,
	// result
	output logic                         done,
	output logic                         found,
	output logic [kmp_pkg::POS_W-1:0]    match_position
);
	import kmp_pkg::*;

	localparam int unsigned IW  = $clog2(MAX_PATTERN + 1);
	localparam int unsigned AW  = $clog2(MAX_PATTERN);
	localparam int unsigned CW0 = $clog2(MAX_PATTERN + 2);
	localparam int unsigned CW  = (CW0 > LEN_W) ? CW0 : LEN_W;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_BLD_LOAD = 5'b00010,
		ST_BLD_NV   = 5'b00100,
		ST_BLD_SCAN = 5'b01000,
		ST_TXT      = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [LEN_W-1:0]       plen_q;
	logic [POS_W-1:0]       start_q;
	logic [LEN_W-1:0]       ipp_q;
	logic [CW-1:0]          cursor_q;
	logic [POS_W-1:0]       cnt_q;
	logic                   found_q;
	logic [POS_W-1:0]       fpos_q;
	logic                   done_q;
	logic [CW-1:0]          i_q;
	logic [CW-1:0]          k_q;
	logic [SYMBOL_BITS-1:0] key_q;

	op_t                    op_in;
	logic                   accept;
	logic [SYMBOL_BITS+SYM_W-1:0] sym_ext;
	logic [SYMBOL_BITS-1:0] sym_w;
	logic [CW-1:0]          plen_ext;
	logic [CW-1:0]          len;
	logic                   slot_ok;

	logic [CW-1:0]          b_pos;
	logic [CW-1:0]          a_off;
	logic [CW-1:0]          b_off;
	logic [CW-1:0]          c_off;
	logic [CW-1:0]          wr_pos;
	logic [CW-1:0]          wr_off;
	cell_we_t               wr_we;
	logic [IW-1:0]          brd_wd;
	logic [IW-1:0]          nv_wd;

	logic [SYMBOL_BITS-1:0] sym_a;
	logic [IW-1:0]          nxt_a;
	logic                   eq_b;
	logic [IW-1:0]          nv_b;
	logic [IW-1:0]          brd_c;

	logic                   bld_step;
	logic                   txt_skip;
	logic                   hit_over;
	logic                   scan_jump;
	logic                   hit_end;
	logic                   txt_jump;
	logic                   fin;
	logic [CW-1:0]          nv_ext;
	logic [CW-1:0]          off;
	logic [POS_W-1:0]       off_ext;
	logic [POS_W-1:0]       match_pos;

	// Command handshake and input decode
	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign op_in   = op_t'(operation);
	assign sym_ext = {{SYMBOL_BITS{1'b0}}, symbol};
	assign sym_w   = sym_ext[SYMBOL_BITS-1:0];
	assign slot_ok = (pattern_slot != '0) && (CW'(pattern_slot) <= CW'(MAX_PATTERN));

	// Active pattern length: zero counts as one, saturate at the row size
	assign plen_ext = CW'(plen_q);
	assign len = (plen_q == '0) ? CW'(1) :
		((plen_ext > CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : plen_ext);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= LEN_W'(1);
			start_q <= POS_W'(1);
			ipp_q   <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PATTERN_LENGTH: plen_q  <= cfg_data[LEN_W-1:0];
				REG_SEARCH_START:   start_q <= cfg_data[POS_W-1:0];
				REG_INIT_POSITION:  ipp_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Cell selection: a = build position, b = compare position, c = fallback
	assign b_pos = (state_q == ST_TXT) ? cursor_q : (k_q + CW'(1));
	assign a_off = i_q - CW'(1);
	assign b_off = b_pos - CW'(1);
	assign c_off = k_q - CW'(1);

	// Cell writes
	always_comb begin
		wr_pos = CW'(1);
		wr_we  = '0;
		brd_wd = '0;
		nv_wd  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op_in == OP_LOAD && slot_ok) begin
					wr_pos       = CW'(pattern_slot);
					wr_we.sym_we = 1'b1;
				end else if (accept && op_in == OP_BUILD) begin
					wr_we.brd_we = 1'b1;
					wr_we.nv_we  = 1'b1;
				end
			end
			ST_BLD_NV: begin
				wr_pos      = i_q;
				wr_we.nv_we = 1'b1;
				nv_wd       = eq_b ? nv_b : b_pos[IW-1:0];
			end
			ST_BLD_SCAN: begin
				wr_pos       = i_q;
				wr_we.brd_we = !bld_step;
				brd_wd       = k_q[IW-1:0] + IW'(eq_b);
			end
			default: ;
		endcase
	end
	assign wr_off = wr_pos - CW'(1);

	kmp_cell_row #(
		.MAX_PATTERN(MAX_PATTERN),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_row (
		.clk      (clk),
		.wr_idx   (wr_off[AW-1:0]),
		.wr_we    (wr_we),
		.sym_wdata(sym_w),
		.brd_wdata(brd_wd),
		.nv_wdata (nv_wd),
		.key      (key_q),
		.rd_a_idx (a_off[AW-1:0]),
		.rd_b_idx (b_off[AW-1:0]),
		.rd_c_idx (c_off[AW-1:0]),
		.sym_a    (sym_a),
		.nxt_a    (nxt_a),
		.eq_b     (eq_b),
		.nv_b     (nv_b),
		.brd_c    (brd_c)
	);

	// Step decisions for build fallback and text cursor walk
	always_comb begin
		bld_step  = (state_q == ST_BLD_SCAN) && (k_q != '0) && !eq_b;
		txt_skip  = found_q || (cnt_q < start_q);
		hit_over  = (cursor_q > len);
		scan_jump = !txt_skip && !hit_over && (cursor_q != '0) && !eq_b;
		hit_end   = !txt_skip && !hit_over && !scan_jump && (cursor_q == len);
		txt_jump  = (state_q == ST_TXT) && scan_jump;
		nv_ext    = CW'(nv_b);
		off       = hit_over ? len : (len - CW'(1));
		off_ext   = POS_W'(off);
		match_pos = (cnt_q >= off_ext) ? (cnt_q - off_ext) : '0;
		unique case (state_q)
			ST_IDLE:     fin = accept && (op_in != OP_TEXT) &&
				((op_in != OP_BUILD) || (len < CW'(2)));
			ST_BLD_SCAN: fin = !bld_step && (i_q == len);
			ST_TXT:      fin = !scan_jump;
			default:     fin = 1'b0;
		endcase
	end

	// Control and result state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= CW'(1);
			cnt_q    <= '0;
			found_q  <= 1'b0;
			fpos_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= fin;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op_in == OP_BUILD) begin
						cursor_q <= CW'(ipp_q);
						cnt_q    <= '0;
						found_q  <= 1'b0;
						fpos_q   <= '0;
						if (len >= CW'(2)) begin
							state_q <= ST_BLD_LOAD;
						end
					end else if (accept && op_in == OP_TEXT) begin
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + POS_W'(1);
						end
						state_q <= ST_TXT;
					end
				end
				ST_BLD_LOAD: state_q <= ST_BLD_NV;
				ST_BLD_NV:   state_q <= ST_BLD_SCAN;
				ST_BLD_SCAN: begin
					if (!bld_step) begin
						state_q <= (i_q == len) ? ST_IDLE : ST_BLD_LOAD;
					end
				end
				ST_TXT: begin
					if (!txt_skip) begin
						if (hit_over) begin
							found_q <= 1'b1;
							fpos_q  <= match_pos;
						end else if (scan_jump) begin
							cursor_q <= (nv_ext < cursor_q) ? nv_ext : '0;
						end else begin
							cursor_q <= cursor_q + CW'(1);
							if (hit_end) begin
								found_q <= 1'b1;
								fpos_q  <= match_pos;
							end
						end
					end
					if (!scan_jump) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Build sweep position, border candidate and compare key
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				i_q <= CW'(2);
				if (accept) begin
					key_q <= sym_w;
				end
			end
			ST_BLD_LOAD: begin
				key_q <= sym_a;
				k_q   <= CW'(nxt_a) - CW'(1);
			end
			ST_BLD_SCAN: begin
				if (bld_step) begin
					k_q <= CW'(brd_c);
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	// Result beat
	assign done           = done_q;
	assign found          = found_q;
	assign match_position = fpos_q;

	// Checks
	`KMP_ASSERT_NOW(a_done_idle, done_q, !busy, "result beat while busy")
	`KMP_ASSERT_NEXT(a_found_hold, found_q && !(accept && op_in == OP_BUILD), found_q,
		"found dropped without a build")
	`KMP_ASSERT_NEXT(a_short_op, accept && op_in != OP_TEXT && op_in != OP_BUILD, done_q,
		"load beat gave no result")
	`KMP_ASSERT_NEXT(a_jump_down, txt_jump, cursor_q < $past(cursor_q),
		"nextval jump did not move the cursor back")
	`KMP_ASSERT_NOW(a_border_short, state_q == ST_BLD_SCAN, k_q < i_q,
		"border candidate not below build position")

endmodule
